[rtl/core/bounded_priority_queue_defines.svh]
// assertion helpers used by the datapath
`ifndef BOUNDED_PRIORITY_QUEUE_DEFINES_SVH
`define BOUNDED_PRIORITY_QUEUE_DEFINES_SVH

// checked on every rising edge, off while in reset
`define BPQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define BPQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/bpq_pkg.sv]
package bpq_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VAL_W = 32;
	localparam int PRI_W = 32;
	localparam int OCC_W = 5;
	localparam int STATUS_W = 2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic opcode;
		logic signed [VAL_W-1:0] item_value;
		logic signed [PRI_W-1:0] item_priority;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic signed [VAL_W-1:0] removed_value;
		logic signed [PRI_W-1:0] removed_priority;
		logic [OCC_W-1:0] occupancy;
	} out_item_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last_addr;
		logic out_free;
	} dp_sts_t;

endpackage

[rtl/core/bpq_ram.sv]
module bpq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/core/bpq_ctrl.sv]
module bpq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bpq_pkg::dp_sts_t   sts,
	output bpq_pkg::ctrl_cmd_t cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_addr) begin
					state_d = S_DRAIN;
				end
			end
			// last slot is compared here
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/core/bpq_datapath.sv]
`include "bounded_priority_queue_defines.svh"

module bpq_datapath #(
	parameter int CAPACITY = bpq_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bpq_pkg::in_item_t   in_data,
	input  bpq_pkg::ctrl_cmd_t  cmd,
	output bpq_pkg::dp_sts_t    sts,
	output logic                out_valid,
	input  logic                out_ready,
	output bpq_pkg::out_item_t  out_data
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int ENT_W = bpq_pkg::VAL_W + bpq_pkg::PRI_W;
	localparam int OCC_W = bpq_pkg::OCC_W;

	bpq_pkg::in_item_t  item_q;
	bpq_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic [IDX_W-1:0]    scan_addr_q;

	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic [ENT_W-1:0] rd_entry;

	logic                                dup_q;
	logic                                found_free_q;
	logic [IDX_W-1:0]                    free_idx_q;
	logic                                found_best_q;
	logic [IDX_W-1:0]                    best_idx_q;
	logic signed [bpq_pkg::VAL_W-1:0]    best_val_q;
	logic signed [bpq_pkg::PRI_W-1:0]    best_pri_q;

	logic signed [bpq_pkg::VAL_W-1:0] rd_val;
	logic signed [bpq_pkg::PRI_W-1:0] rd_pri;
	logic                             slot_valid;
	logic                             is_insert;
	logic                             ins_ok;
	logic                             del_ok;
	logic [bpq_pkg::STATUS_W-1:0]     status_d;
	logic [CNT_W+OCC_W-1:0]           occ_ext;

	bpq_ram #(
		.WIDTH(ENT_W),
		.DEPTH(CAPACITY)
	) u_entry_ram (
		.clk    (clk),
		.wr_en  (cmd.commit && ins_ok),
		.wr_addr(free_idx_q),
		.wr_data({item_q.item_value, item_q.item_priority}),
		.rd_en  (cmd.issue),
		.rd_addr(scan_addr_q),
		.rd_data(rd_entry)
	);

	assign rd_val = $signed(rd_entry[ENT_W-1:bpq_pkg::PRI_W]);
	assign rd_pri = $signed(rd_entry[bpq_pkg::PRI_W-1:0]);
	assign slot_valid = valid_q[cmp_idx_s1];

	assign is_insert = (item_q.opcode == bpq_pkg::OP_INSERT);
	assign ins_ok = is_insert && !dup_q && found_free_q;
	assign del_ok = !is_insert && found_best_q;

	assign sts.last_addr = (scan_addr_q == IDX_W'(CAPACITY - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		if (is_insert) begin
			if (dup_q) begin
				status_d = bpq_pkg::ST_DUP;
			end else if (!found_free_q) begin
				status_d = bpq_pkg::ST_FULL;
			end else begin
				status_d = bpq_pkg::ST_OK;
			end
		end else begin
			status_d = found_best_q ? bpq_pkg::ST_OK : bpq_pkg::ST_EMPTY;
		end
	end

	always_comb begin
		if (ins_ok) begin
			count_d = count_q + 1'b1;
		end else if (del_ok) begin
			count_d = count_q - 1'b1;
		end else begin
			count_d = count_q;
		end
	end

	// occupancy is the low bits of the count
	assign occ_ext = {{OCC_W{1'b0}}, count_d};

	// input capture and scan address
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_addr_q <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			if (cmd.start) begin
				scan_addr_q <= '0;
			end else if (cmd.issue) begin
				scan_addr_q <= scan_addr_q + 1'b1;
			end
			cmp_vld_s1 <= cmd.issue;
			cmp_idx_s1 <= scan_addr_q;
		end
	end

	// running search over the slot read last cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_q <= 1'b0;
			found_free_q <= 1'b0;
			found_best_q <= 1'b0;
		end else if (cmd.start) begin
			dup_q <= 1'b0;
			found_free_q <= 1'b0;
			found_best_q <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (slot_valid && rd_pri == item_q.item_priority) begin
				dup_q <= 1'b1;
			end
			if (!slot_valid) begin
				found_free_q <= 1'b1;
			end
			if (slot_valid) begin
				found_best_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_vld_s1) begin
			if (!slot_valid && !found_free_q) begin
				free_idx_q <= cmp_idx_s1;
			end
			if (slot_valid && (!found_best_q || rd_pri > best_pri_q)) begin
				best_idx_q <= cmp_idx_s1;
				best_val_q <= rd_val;
				best_pri_q <= rd_pri;
			end
		end
	end

	// store state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_d;
			if (ins_ok) begin
				valid_q[free_idx_q] <= 1'b1;
			end else if (del_ok) begin
				valid_q[best_idx_q] <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.status <= status_d;
			out_q.removed_value <= del_ok ? best_val_q : '0;
			out_q.removed_priority <= del_ok ? best_pri_q : '0;
			out_q.occupancy <= occ_ext[OCC_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`BPQ_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "stored count above capacity")
	`BPQ_ASSERT(a_insert_counts, cmd.commit && ins_ok |=> count_q == $past(count_q) + 1'b1,
		"accepted insert did not raise the count")
	`BPQ_ASSERT(a_commit_free, cmd.commit |-> sts.out_free, "result written over a pending one")
	`BPQ_ASSERT(a_result_source, $rose(out_valid_q) |-> $past(cmd.commit),
		"result appeared without a commit")

endmodule

[rtl/core/bounded_priority_queue.sv]
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_data   (bpq_pkg::in_item_t)
// out     | output    | out_valid / out_ready | out_data  (bpq_pkg::out_item_t)
//
// no new input is taken until the item before it has committed: the entry
// memory has one read port and is scanned one slot per cycle for duplicate, free
// slot and maximum priority, then a drain state ends the compare and a done state commits.
// arst_n clears all valid bits and the count, so the store starts empty at once.
// a result waiting in the output register does not block the next input transfer;
// the commit of the following item waits until that register is free.
module bounded_priority_queue #(
	parameter int CAPACITY = bpq_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bpq_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bpq_pkg::out_item_t out_data
);

	bpq_pkg::ctrl_cmd_t cmd;
	bpq_pkg::dp_sts_t   sts;

	bpq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bpq_datapath #(
		.CAPACITY(CAPACITY)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
	import bpq_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int RANDOM_OPS = 1130;
	localparam int CYCLE_LIMIT = 300000;

	// shadow copy of the store, predicts one result per accepted operation
	class pq_scoreboard;
		logic signed [VAL_W-1:0] slot_value [CAP];
		logic signed [PRI_W-1:0] slot_priority [CAP];
		bit slot_used [CAP];
		int held;
		int errors;
		out_item_t expected_q [$];

		function new();
			held = 0;
			errors = 0;
			foreach (slot_used[i]) slot_used[i] = 1'b0;
		endfunction

		function void note_input(in_item_t op);
			out_item_t res;
			int free_slot;
			int best;
			bit dup;
			res = '0;
			free_slot = -1;
			best = -1;
			dup = 1'b0;
			res.status = ST_OK;
			if (op.opcode == OP_INSERT) begin
				for (int i = 0; i < CAP; i++) begin
					if (slot_used[i]) begin
						if (slot_priority[i] == op.item_priority)
							dup = 1'b1;
					end else if (free_slot < 0) begin
						free_slot = i;
					end
				end
				// a held priority wins over a full store
				if (dup) begin
					res.status = ST_DUP;
				end else if (free_slot < 0) begin
					res.status = ST_FULL;
				end else begin
					slot_value[free_slot] = op.item_value;
					slot_priority[free_slot] = op.item_priority;
					slot_used[free_slot] = 1'b1;
					held++;
				end
			end else begin
				for (int i = 0; i < CAP; i++) begin
					if (slot_used[i] && (best < 0 || slot_priority[i] > slot_priority[best]))
						best = i;
				end
				if (best < 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.removed_value = slot_value[best];
					res.removed_priority = slot_priority[best];
					slot_used[best] = 1'b0;
					held--;
				end
			end
			res.occupancy = OCC_W'(held);
			expected_q.push_back(res);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("result with no operation outstanding");
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.removed_value !== want.removed_value)
				report_mismatch($sformatf("removed_value %0d, want %0d",
					got.removed_value, want.removed_value));
			if (got.removed_priority !== want.removed_priority)
				report_mismatch($sformatf("removed_priority %0d, want %0d",
					got.removed_priority, want.removed_priority));
			if (got.occupancy !== want.occupancy)
				report_mismatch($sformatf("occupancy %0d, want %0d",
					got.occupancy, want.occupancy));
		endtask

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	int send_idle = 26;
	int recv_idle = 48;
	int cycles = 0;
	pq_scoreboard sb = new();

	bounded_priority_queue #(
		.CAPACITY(CAP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	function automatic in_item_t mk_op(logic opcode, logic [31:0] value, logic [31:0] prio);
		in_item_t op;
		op.opcode = opcode;
		op.item_value = value;
		op.item_priority = prio;
		return op;
	endfunction

	// mode 0 mostly fills, mode 1 mostly drains, mode 2 is balanced
	function automatic in_item_t rand_op(int mode);
		int r;
		logic opcode;
		logic [31:0] prio;
		r = $urandom_range(99);
		case (mode)
			0: opcode = (r < 85) ? OP_INSERT : OP_DELETE;
			1: opcode = (r < 15) ? OP_INSERT : OP_DELETE;
			default: opcode = (r < 50) ? OP_INSERT : OP_DELETE;
		endcase
		// narrow pool so that duplicates are common
		r = $urandom_range(99);
		if (r < 50) begin
			prio = $urandom_range(24) - 12;
		end else if (r < 60) begin
			case ($urandom_range(3))
				0: prio = 32'h7fff_ffff;
				1: prio = 32'h8000_0000;
				2: prio = 32'hffff_ffff;
				default: prio = 32'h0000_0000;
			endcase
		end else begin
			prio = $urandom;
		end
		return mk_op(opcode, $urandom, prio);
	endfunction

	task automatic send_op(in_item_t op);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= op;
		do @(posedge clk); while (!in_ready);
		sb.note_input(op);
		@(negedge clk);
	endtask

	initial begin
		int left;
		int mode;
		int burst;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty store, extreme values, duplicates, full store, ordered removal
		send_op(mk_op(OP_DELETE, 32'h1234_5678, 32'hffff_ffff));
		send_op(mk_op(OP_INSERT, 32'h8000_0000, 32'h7fff_ffff));
		send_op(mk_op(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff));
		send_op(mk_op(OP_INSERT, 32'hffff_ffff, 32'h8000_0000));
		for (int k = 0; k < 14; k++)
			send_op(mk_op(OP_INSERT, $urandom, k * 37 - 200));
		send_op(mk_op(OP_INSERT, 32'h0000_0000, 32'd5000));
		send_op(mk_op(OP_INSERT, 32'h0000_0000, 32'h8000_0000));
		repeat (3) send_op(mk_op(OP_DELETE, $urandom, $urandom));

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle = 26;
					recv_idle = 48;
				end
				1: begin
					send_idle = 48;
					recv_idle = 26;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			left = RANDOM_OPS / 3;
			while (left > 0) begin
				mode = $urandom_range(2);
				burst = $urandom_range(40, 8);
				for (int b = 0; b < burst && left > 0; b++) begin
					send_op(rand_op(mode));
					left--;
				end
			end
		end
		in_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (2 * CAP + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
